// File: rtl/bmpt_pkg.sv
package bmpt_pkg;

  localparam int RAM_DEPTH_DEF = 4096;
  localparam int ROM_DEPTH_DEF = 8192;

  localparam logic [7:0]  ADAPTER_PAGE = 8'hD0;
  localparam logic [7:0]  ADAPTER_MASK = 8'h13;
  localparam logic [15:0] ROM_BASE     = 16'hE000;
  localparam logic [7:0]  XON_CHAR     = 8'h11;
  localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0]  KBD_CTL_OK   = 8'hA7;
  localparam logic [7:0]  DSP_DDR_OK   = 8'h7F;
  localparam int          DSP_ENA_BIT  = 2;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_LOAD  = 2'd2
  } req_e;

  typedef enum logic [7:0] {
    SEL_KBD_DATA = 8'h10,
    SEL_KBD_CTL  = 8'h11,
    SEL_DSP_DATA = 8'h12,
    SEL_DSP_CTL  = 8'h13
  } sel_e;

  // keyboard byte: lowercase to uppercase, strobe bit set
  function automatic logic [7:0] kbd_fold(input logic [7:0] k);
    logic [7:0] r;
    r = k;
    if (k >= 8'h61 && k <= 8'h7A) begin
      r = k - 8'h20;
    end
    return r | 8'h80;
  endfunction

  // display byte: 7 bits, fold lowercase, non-printable becomes newline
  function automatic logic [7:0] dsp_fold(input logic [7:0] w);
    logic [7:0] d;
    d = w & 8'h7F;
    if (d >= 8'h60) begin
      d = d & 8'h5F;
    end
    if (d >= 8'h20 && d <= 8'h5F) begin
      return d;
    end
    return NEWLINE_CHAR;
  endfunction

endpackage

// File: rtl/bmpt_ram.sv
module bmpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bus_memory_and_pia_terminal.sv
// channel   direction  handshake            ports
// request   in         start_i && !busy_o   req_type_i address_i write_data_i key_char_i
//                                           key_waiting_i term_ready_i
// result    out        valid_o (one cycle)  read_data_o term_char_o term_char_valid_o
//                                           unhandled_o
//
// one word per cycle while busy_o is low; the result shows in the cycle after acceptance, set by the
// registered read port of the ram and rom.
// after reset the ram is swept to zero, one entry a cycle, with busy_o high until the
// last entry is written; afterwards busy_o stays low.
// the receiver cannot stall: each result is valid for exactly one cycle.
module bus_memory_and_pia_terminal #(
  parameter int RAM_DEPTH = bmpt_pkg::RAM_DEPTH_DEF,
  parameter int ROM_DEPTH = bmpt_pkg::ROM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  key_char_i,
  input  logic        key_waiting_i,
  input  logic        term_ready_i,
  output logic        valid_o,
  output logic [7:0]  read_data_o,
  output logic [7:0]  term_char_o,
  output logic        term_char_valid_o,
  output logic        unhandled_o
);

  import bmpt_pkg::*;

  localparam int RAM_AW = $clog2(RAM_DEPTH);
  localparam int ROM_AW = $clog2(ROM_DEPTH);

  logic              acc;
  logic              in_ram;
  logic              adapter;
  logic [7:0]        sel;
  logic [RAM_AW-1:0] ram_addr;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [ROM_AW-1:0] rom_addr;
  logic              rom_we;
  logic [7:0]        rom_rdata;
  logic [18:0]       rom_rem;

  logic              clearing_q, clearing_d;
  logic [RAM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic              dsp_ena_q, dsp_ena_d;
  logic              valid_q;
  logic              src_ram_q, src_ram_d;
  logic              src_rom_q, src_rom_d;
  logic [7:0]        rd_fix_q, rd_fix_d;
  logic [7:0]        tc_q, tc_d;
  logic              tv_q, tv_d;
  logic              unh_q, unh_d;

  assign busy_o  = clearing_q;
  assign acc     = start_i && !clearing_q;
  assign in_ram  = {1'b0, address_i} < 17'(RAM_DEPTH);
  assign adapter = address_i[15:8] == ADAPTER_PAGE;
  assign sel     = address_i[7:0] & ADAPTER_MASK;

  // rom entry: (address & 0x1fff) mod ROM_DEPTH, quotient has at most five bits
  always_comb begin
    rom_rem = {6'b0, address_i[12:0]};
    for (int i = 4; i >= 0; i--) begin
      if (rom_rem >= (19'(ROM_DEPTH) << i)) begin
        rom_rem = rom_rem - (19'(ROM_DEPTH) << i);
      end
    end
  end
  assign rom_addr = rom_rem[ROM_AW-1:0];
  assign rom_we   = acc && (req_type_i == REQ_LOAD);

  assign ram_addr  = clearing_q ? clr_cnt_q : address_i[RAM_AW-1:0];
  assign ram_we    = clearing_q || (acc && (req_type_i == REQ_WRITE) && in_ram);
  assign ram_wdata = clearing_q ? 8'h00 : write_data_i;

  bmpt_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bmpt_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .addr_i  (rom_addr),
    .wdata_i (write_data_i),
    .rdata_o (rom_rdata)
  );

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // decode at acceptance; only the memory data is picked up in the following cycle
  always_comb begin
    src_ram_d = 1'b0;
    src_rom_d = 1'b0;
    rd_fix_d  = 8'h00;
    tc_d      = 8'h00;
    tv_d      = 1'b0;
    unh_d     = 1'b0;
    dsp_ena_d = dsp_ena_q;
    unique case (req_type_i)
      REQ_READ: begin
        priority if (in_ram) begin
          src_ram_d = 1'b1;
        end else if (address_i >= ROM_BASE) begin
          src_rom_d = 1'b1;
        end else if (adapter && sel == SEL_KBD_DATA) begin
          rd_fix_d = kbd_fold(key_char_i);
          tc_d     = XON_CHAR;
          tv_d     = 1'b1;
        end else if (adapter && sel == SEL_KBD_CTL) begin
          rd_fix_d = key_waiting_i ? 8'h80 : 8'h00;
        end else if (adapter && sel == SEL_DSP_DATA) begin
          rd_fix_d = term_ready_i ? 8'h00 : 8'h80;
        end else begin
          unh_d = 1'b1;
        end
      end
      REQ_WRITE: begin
        priority if (in_ram) begin
          unh_d = 1'b0;
        end else if (adapter && sel == SEL_KBD_CTL) begin
          unh_d = write_data_i != KBD_CTL_OK;
        end else if (adapter && sel == SEL_DSP_DATA) begin
          if (dsp_ena_q) begin
            tc_d = dsp_fold(write_data_i);
            tv_d = 1'b1;
          end else begin
            unh_d = write_data_i != DSP_DDR_OK;
          end
        end else if (adapter && sel == SEL_DSP_CTL) begin
          dsp_ena_d = write_data_i[DSP_ENA_BIT];
        end else begin
          unh_d = 1'b1;
        end
      end
      REQ_LOAD: begin
        unh_d = 1'b0;
      end
      default: begin
        unh_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      dsp_ena_q  <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      valid_q    <= acc;
      if (acc) begin
        dsp_ena_q <= dsp_ena_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      src_ram_q <= src_ram_d;
      src_rom_q <= src_rom_d;
      rd_fix_q  <= rd_fix_d;
      tc_q      <= tc_d;
      tv_q      <= tv_d;
      unh_q     <= unh_d;
    end
  end

  assign valid_o           = valid_q;
  assign read_data_o       = src_ram_q ? ram_rdata : (src_rom_q ? rom_rdata : rd_fix_q);
  assign term_char_o       = tc_q;
  assign term_char_valid_o = tv_q;
  assign unhandled_o       = unh_q;

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !valid_o)
    else $error("result strobe during ram clearing");

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (valid_o == $past(start_i && !busy_o)))
    else $error("result strobe without matching acceptance");

  a_sent_char_is_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && term_char_valid_o) |-> !unhandled_o)
    else $error("terminal character on an unhandled access");

  a_clear_ends_at_last_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_cnt_q) == RAM_AW'(RAM_DEPTH - 1)))
    else $error("ram clearing ended early");

endmodule
